// ===== rtl/duplicate_request_filter_table_core_defines.svh =====
// Assertion macros for the duplicate request filter table.
`ifndef DUPLICATE_REQUEST_FILTER_TABLE_CORE_DEFINES_SVH
`define DUPLICATE_REQUEST_FILTER_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define DRTF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that cons holds in the cycle after ante.
`define DRTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DRTF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DRTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/drtf_pkg.sv =====
// Shared types and constants of the duplicate request filter table.
package drtf_pkg;

	localparam int SLOTS_DEFAULT = 32;
	localparam int SLOT_W        = 5;
	localparam int KEY_W         = 480;
	localparam int IN_TDATA_W    = 488;
	localparam int OUT_TDATA_W   = 8;
	localparam int STATUS_W      = 2;

	typedef enum logic {
		MODE_INSERT  = 1'b0,
		MODE_RELEASE = 1'b1
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_ACCEPTED  = 2'd0,
		STATUS_DUPLICATE = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_RELEASED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic ready;
		logic load;
		logic scan;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_release;
		logic scan_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ===== rtl/drtf_ctrl.sv =====
// Controller state machine: accept, scan the table, flush the compare, deliver.
module drtf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  drtf_pkg::ctrl_sts_t sts,
	output drtf_pkg::ctrl_cmd_t cmd
);

	drtf_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drtf_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			drtf_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (s_tvalid) begin
					cmd.load   = 1'b1;
					state_next = sts.in_release ? drtf_pkg::ST_RESULT : drtf_pkg::ST_SCAN;
				end
			end
			drtf_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_next = drtf_pkg::ST_FLUSH;
				end
			end
			drtf_pkg::ST_FLUSH: begin
				// last read is compared in this cycle
				state_next = drtf_pkg::ST_RESULT;
			end
			drtf_pkg::ST_RESULT: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_next = drtf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = drtf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/drtf_dp.sv =====
// Datapath: key register, key memory, valid bits, scan compare and result register.
module drtf_dp #(
	parameter int SLOTS = drtf_pkg::SLOTS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  drtf_pkg::ctrl_cmd_t                 cmd,
	output drtf_pkg::ctrl_sts_t                 sts,
	input  logic [drtf_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [drtf_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic [drtf_pkg::STATUS_W-1:0]       m_tuser
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
	localparam int SLOT_LO = 0;
	localparam int KEY_LO  = drtf_pkg::SLOT_W;

	logic [drtf_pkg::KEY_W-1:0]  mem [SLOTS];
	logic [drtf_pkg::KEY_W-1:0]  key_q;
	logic [drtf_pkg::KEY_W-1:0]  rd_data_s1;
	drtf_pkg::mode_t             mode_q;
	logic [drtf_pkg::SLOT_W-1:0] slot_q;
	logic [IW-1:0]               cnt_q;
	logic [SLOTS-1:0]            valid_q;
	logic                        issue_s1;
	logic                        vld_s1;
	logic [IW-1:0]               idx_s1;
	logic                        hit_q;
	logic                        have_free_q;
	logic [IW-1:0]               free_idx_q;
	logic                        out_valid_q;
	drtf_pkg::status_t           out_status_q;
	logic [drtf_pkg::SLOT_W-1:0] out_slot_q;

	logic [8:0]                  rel_ext;
	logic                        rel_in_range;
	logic [IW-1:0]               rel_idx;
	logic [8:0]                  free_ext;
	logic                        mem_we;
	drtf_pkg::status_t           res_status;
	logic [drtf_pkg::SLOT_W-1:0] res_slot;

	assign rel_ext      = 9'(slot_q);
	assign rel_in_range = rel_ext < 9'(SLOTS);
	assign rel_idx      = rel_ext[IW-1:0];
	assign free_ext     = 9'(free_idx_q);

	always_comb begin
		mem_we     = 1'b0;
		res_slot   = '0;
		res_status = drtf_pkg::STATUS_ACCEPTED;
		priority if (mode_q == drtf_pkg::MODE_RELEASE) begin
			res_status = drtf_pkg::STATUS_RELEASED;
			res_slot   = slot_q;
		end else if (hit_q) begin
			res_status = drtf_pkg::STATUS_DUPLICATE;
		end else if (!have_free_q) begin
			res_status = drtf_pkg::STATUS_FULL;
		end else begin
			res_slot = free_ext[drtf_pkg::SLOT_W-1:0];
			mem_we   = cmd.finish;
		end
	end

	assign sts.in_release = (s_tuser == drtf_pkg::MODE_RELEASE);
	assign sts.scan_last  = (cnt_q == LAST_IDX);
	assign sts.out_free   = !out_valid_q || m_tready;

	// key memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[free_idx_q] <= key_q;
		end
		rd_data_s1 <= mem[cnt_q];
	end

	always_ff @(posedge clk) begin
		vld_s1 <= valid_q[cnt_q];
		idx_s1 <= cnt_q;
		if (cmd.load) begin
			mode_q <= drtf_pkg::mode_t'(s_tuser);
			slot_q <= s_tdata[SLOT_LO +: drtf_pkg::SLOT_W];
			key_q  <= s_tdata[KEY_LO +: drtf_pkg::KEY_W];
		end
		if (issue_s1 && !vld_s1 && !have_free_q) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.finish) begin
			out_status_q <= res_status;
			out_slot_q   <= res_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			valid_q     <= '0;
			issue_s1    <= 1'b0;
			hit_q       <= 1'b0;
			have_free_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			issue_s1 <= cmd.scan;
			if (cmd.load) begin
				cnt_q       <= '0;
				hit_q       <= 1'b0;
				have_free_q <= 1'b0;
			end else begin
				if (cmd.scan) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (issue_s1) begin
					if (vld_s1 && rd_data_s1 == key_q) begin
						hit_q <= 1'b1;
					end
					if (!vld_s1) begin
						have_free_q <= 1'b1;
					end
				end
			end
			if (cmd.finish) begin
				if (mode_q == drtf_pkg::MODE_RELEASE) begin
					if (rel_in_range) begin
						valid_q[rel_idx] <= 1'b0;
					end
				end else if (mem_we) begin
					valid_q[free_idx_q] <= 1'b1;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = drtf_pkg::OUT_TDATA_W'(out_slot_q);

endmodule

// ===== rtl/duplicate_request_filter_table_core.sv =====
// Top level of the duplicate request filter table.
// Filters retransmitted requests against a table of requests in progress.
// Input channel s_*: one item per request. s_tuser is the mode (0 insert, 1 release).
// In insert mode the key fields are compared against every valid slot; a match
// returns duplicate, otherwise the lowest free slot takes the key and its index is
// returned, or table full when no slot is free. Release clears the named slot.
// Output channel m_*: one item per input item, m_tuser the status
// (0 accepted, 1 duplicate, 2 full, 3 released), m_tdata the slot index.
// Sequence: an insert is accepted, then the key memory is scanned, one entry per cycle
// through its single read port; a flush state compares the last read, and the result
// state loads the output register once it is free, then the block is idle again.
// A release skips the scan and goes from acceptance straight to the result state.
// The block works on one item at a time; s_tready is high only while idle.
// A result waits in the output register while m_tready is low; the next item may
// be accepted meanwhile, and its own result holds until the register frees.
// Reset clears all valid bits at once; the key memory needs no clearing pass.
`include "duplicate_request_filter_table_core_defines.svh"
module duplicate_request_filter_table_core #(
	parameter int SLOTS = drtf_pkg::SLOTS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// slot[4:0], query_id[20:5], owner_ref[52:21], query_type[68:53],
	// remote_addr_hi[132:69], remote_addr_lo[196:133], local_addr_hi[260:197],
	// local_addr_lo[324:261], iface_addr_hi[388:325], iface_addr_lo[452:389],
	// port_pair[484:453], zero pad[487:485]
	input  logic [drtf_pkg::IN_TDATA_W-1:0]  s_tdata,
	// mode[0]
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// slot_index[4:0], zero pad[7:5]
	output logic [drtf_pkg::OUT_TDATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [drtf_pkg::STATUS_W-1:0]    m_tuser
);

	drtf_pkg::ctrl_cmd_t cmd;
	drtf_pkg::ctrl_sts_t sts;

	drtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	drtf_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	assign s_tready = cmd.ready;

	`DRTF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "busy")
	`DRTF_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.finish, !m_tvalid || m_tready, "overwrite")
	`DRTF_ASSERT_NEXT(a_result_shown, clk, arst_n, cmd.finish, m_tvalid, "result not shown")

endmodule
